// ----- design/dpcm3n_pkg.sv -----
// ----------------------------------------------------------------------------
// dpcm3n_pkg: shared types and constants for the three-neighbor DPCM block
// Pixel and column widths, line buffer geometry, image size reset value,
// the reciprocal used for the divide by three, and the line buffer write port.
// ----------------------------------------------------------------------------
package dpcm3n_pkg;

   // Line buffer geometry
   localparam int MaxSize    = 1024;
   localparam int AddrWidth  = $clog2(MaxSize);
   localparam int PixelWidth = 8;

   // Image size register
   localparam int SizeWidth = 11;
   localparam logic [SizeWidth-1:0] SizeReset = SizeWidth'(512);
   localparam logic [SizeWidth-1:0] SizeMin   = SizeWidth'(2);
   localparam logic [SizeWidth-1:0] SizeMax   = SizeWidth'(MaxSize);

   // floor(x / 3) == (x * 683) >> 11 for every x below 2048
   localparam int SumWidth   = PixelWidth + 2;
   localparam int Recip3     = 683;
   localparam int RecipShift = 11;
   localparam int ProdWidth  = SumWidth + 10;

   typedef logic [PixelWidth-1:0] pixel_type;
   typedef logic [AddrWidth-1:0]  col_type;
   typedef logic [SizeWidth-1:0]  size_type;

   // Line buffer write port
   typedef struct packed {
      logic      enable;
      col_type   addr;
      pixel_type data;
   } lb_write_type;

endpackage

// ----- design/dpcm3n_line_buf.sv -----
// ----------------------------------------------------------------------------
// dpcm3n_line_buf: one-row line buffer
// Single write port and single read port; read data is registered, so the
// value for an address given in one cycle is available in the next.
// ----------------------------------------------------------------------------
module dpcm3n_line_buf (
   input  logic                    clock,
   input  dpcm3n_pkg::lb_write_type wr,
   input  dpcm3n_pkg::col_type      rd_addr,
   output dpcm3n_pkg::pixel_type    rd_data
);
   import dpcm3n_pkg::*;

   pixel_type mem [MaxSize];
   pixel_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.enable) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/dpcm3n_checker.sv -----
// ----------------------------------------------------------------------------
// dpcm3n_checker: port-level checks for the DPCM residual block
// Watches the request and response channels of the top level; bound below.
// ----------------------------------------------------------------------------
module dpcm3n_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [8:0]        rsp_residual,
   input dpcm3n_pkg::pixel_type    rsp_prediction,
   input logic                     rsp_end_of_row,
   input logic                     rsp_end_of_image
);
   import dpcm3n_pkg::*;

   logic [9:0] pixel_rebuilt;
   assign pixel_rebuilt = {rsp_residual[8], rsp_residual} + {2'b00, rsp_prediction};

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an empty response register never blocks a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // residual plus prediction gives back an 8-bit pixel
   a_residual_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pixel_rebuilt[9:8] == 2'b00)
      else $error("residual and prediction do not rebuild a pixel");

   // end of image is always also end of row
   a_eoi_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_image |-> rsp_end_of_row)
      else $error("end of image without end of row");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_residual)
         && $stable(rsp_prediction))
      else $error("stalled response changed");

endmodule

bind dpcm_three_neighbor_residual_top dpcm3n_checker u_dpcm3n_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_residual     (rsp_residual),
   .rsp_prediction   (rsp_prediction),
   .rsp_end_of_row   (rsp_end_of_row),
   .rsp_end_of_image (rsp_end_of_image)
);

// ----- design/dpcm_three_neighbor_residual_top.sv -----
// Response: the response to a request is registered at the edge that accepts it.
// Throughput: one pixel per cycle unless rsp_ready stalls a held response; the line
// buffer's single read port is read one pixel ahead at the next column, so each pixel needs exactly one read.
// Reset (synchronous): counters, west and northwest pixels and the response valid
// flag clear, image_size returns to 512; the line buffer is not cleared.
// ----------------------------------------------------------------------------
// dpcm_three_neighbor_residual_top: three-neighbor DPCM residual generator
// Predicts each pixel as the rounded mean of its north, northwest and west
// neighbors (zero in the first row and column) and emits pixel minus prediction.
// ----------------------------------------------------------------------------
module dpcm_three_neighbor_residual_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  dpcm3n_pkg::size_type     csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dpcm3n_pkg::pixel_type    req_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [8:0]        rsp_residual,
   output dpcm3n_pkg::pixel_type    rsp_prediction,
   output logic                     rsp_end_of_row,
   output logic                     rsp_end_of_image
);
   import dpcm3n_pkg::*;

   size_type     size_ff;
   col_type      col_ff, col_in;
   col_type      row_ff, row_in;
   pixel_type    west_ff, nw_ff;
   col_type      last_idx;
   col_type      rd_addr;
   pixel_type    north;
   lb_write_type lb_wr;
   logic         accept;
   logic         eor, eoi;
   logic [SumWidth-1:0]  sum_p1;
   logic [ProdWidth-1:0] prod;
   pixel_type    pred;
   logic [8:0]   resid;

   logic         rsp_valid_ff;
   logic [8:0]   resid_ff;
   pixel_type    pred_ff;
   logic         eor_ff, eoi_ff;

   // handshake: take a request whenever the response register frees up
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // image size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeReset;
      end else if (csr_write_enable) begin
         size_ff <= csr_write_data;
      end
   end

   // last row/column index from the size saturated to 2..MaxSize
   always_comb begin
      priority if (size_ff < SizeMin) begin
         last_idx = AddrWidth'(1);
      end else if (size_ff > SizeMax) begin
         last_idx = AddrWidth'(MaxSize - 1);
      end else begin
         last_idx = AddrWidth'(size_ff - SizeWidth'(1));
      end
   end

   assign eor = col_ff >= last_idx;
   assign eoi = eor && (row_ff >= last_idx);

   // position counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (eor) begin
            col_in = '0;
            row_in = eoi ? '0 : row_ff + AddrWidth'(1);
         end else begin
            col_in = col_ff + AddrWidth'(1);
         end
      end
   end

   // line buffer: write current pixel, prefetch north of the next one
   assign rd_addr      = reset ? '0 : col_in;
   assign lb_wr.enable = accept;
   assign lb_wr.addr   = col_ff;
   assign lb_wr.data   = req_pixel;

   dpcm3n_line_buf u_line_buf (
      .clock   (clock),
      .wr      (lb_wr),
      .rd_addr (rd_addr),
      .rd_data (north)
   );

   // prediction: floor((N + NW + W + 1) / 3) by reciprocal multiply
   assign sum_p1 = {2'b00, north} + {2'b00, nw_ff} + {2'b00, west_ff} + SumWidth'(1);
   assign prod   = ProdWidth'(sum_p1) * ProdWidth'(Recip3);
   always_comb begin
      if (row_ff == '0 || col_ff == '0) begin
         pred = '0;
      end else begin
         pred = prod[RecipShift +: PixelWidth];
      end
   end
   assign resid = {1'b0, req_pixel} - {1'b0, pred};

   // neighbor and counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         west_ff <= '0;
         nw_ff   <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            west_ff <= req_pixel;
            nw_ff   <= north;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         resid_ff <= resid;
         pred_ff  <= pred;
         eor_ff   <= eor;
         eoi_ff   <= eoi;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_residual     = $signed(resid_ff);
   assign rsp_prediction   = pred_ff;
   assign rsp_end_of_row   = eor_ff;
   assign rsp_end_of_image = eoi_ff;

endmodule
